>>> hdl/sqt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared types, constants and the word classifier of the query tokenizer.
// ----------------------------------------------------------------------------
package sqt_pkg;

  localparam int MAX_QUERY_BYTES = 4096;
  localparam int POS_W           = 12;
  localparam int LEN_W           = 13;
  localparam int PREFIX_DEPTH    = 8;
  localparam int NUM_KW          = 12;
  localparam int KW_CHARS        = 7;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_QUERY_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_QUERY_BYTES);

  typedef enum logic [3:0] {
    KIND_SELECT   = 4'd0,
    KIND_FROM     = 4'd1,
    KIND_WHERE    = 4'd2,
    KIND_AND      = 4'd3,
    KIND_OR       = 4'd4,
    KIND_BETWEEN  = 4'd5,
    KIND_OPERATOR = 4'd6,
    KIND_COLUMN   = 4'd7,
    KIND_LITERAL  = 4'd8,
    KIND_UNKNOWN  = 4'd9
  } kind_t;

  typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;
  typedef logic [0:KW_CHARS-1][7:0]     kw_text_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic              no_token;
    logic              last;
  } token_t;

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd6, 4'd4, 4'd5, 4'd3, 4'd2, 4'd7, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd2
  };

  localparam kind_t KW_KIND [NUM_KW] = '{
    KIND_SELECT, KIND_FROM, KIND_WHERE, KIND_AND, KIND_OR, KIND_BETWEEN,
    KIND_OPERATOR, KIND_OPERATOR, KIND_OPERATOR, KIND_OPERATOR,
    KIND_OPERATOR, KIND_OPERATOR
  };

  localparam kw_text_t KW_TEXT [NUM_KW] = '{
    '{"S", "E", "L", "E", "C", "T", 8'h00},
    '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00},
    '{"W", "H", "E", "R", "E", 8'h00, 8'h00},
    '{"A", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"B", "E", "T", "W", "E", "E", "N"},
    '{"=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{">", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"<", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"<", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"!", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // keyword table first, then column, literal, unknown
  function automatic kind_t classify(prefix_t prefix, logic [LEN_W-1:0] len,
                                     logic all_wc, logic first_q,
                                     logic [7:0] last_c);
    kind_t k;
    logic  found;
    logic  same;
    k     = KIND_UNKNOWN;
    found = 1'b0;
    for (int i = 0; i < NUM_KW; i++) begin
      same = (len == LEN_W'(KW_LEN[i]));
      for (int j = 0; j < KW_CHARS; j++) begin
        if (j < int'(KW_LEN[i]) && prefix[j] != KW_TEXT[i][j]) begin
          same = 1'b0;
        end
      end
      if (same && !found) begin
        found = 1'b1;
        k     = KW_KIND[i];
      end
    end
    if (!found) begin
      if (all_wc) begin
        k = KIND_COLUMN;
      end else if (first_q && last_c == "'") begin
        k = KIND_LITERAL;
      end else begin
        k = KIND_UNKNOWN;
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sqt_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_in_if
// Query byte channel: valid/ready with one byte and its end flag.
// ----------------------------------------------------------------------------
interface sqt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_query;

  modport source (output valid, output char_code, output end_of_query, input ready);
  modport sink   (input valid, input char_code, input end_of_query, output ready);
endinterface
`default_nettype wire

>>> hdl/sqt_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_out_if
// Token channel: valid/ready with kind, offset, length and end flags.
// ----------------------------------------------------------------------------
interface sqt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [11:0] token_start;
  logic [12:0] token_length;
  logic        no_token;
  logic        last_of_query;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output no_token, output last_of_query,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input no_token, input last_of_query,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/sqt_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_result_fifo
// Four-entry token queue, takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
module sqt_result_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_a,
  input  wire logic            push_b,
  input  wire sqt_pkg::token_t data_a,
  input  wire sqt_pkg::token_t data_b,
  output logic                 room,
  output logic                 valid,
  input  wire logic            pop,
  output sqt_pkg::token_t      data
);
  import sqt_pkg::*;

  token_t      mem_r [4];
  logic [1:0]  head_r, head_nxt;
  logic [1:0]  tail_r, tail_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        do_pop;
  logic [1:0]  n_push;

  assign valid  = (count_r != 3'd0);
  assign room   = (count_r <= 3'd2);
  assign data   = mem_r[head_r];
  assign do_pop = valid && pop;
  assign n_push = {1'b0, push_a} + {1'b0, push_b};

  always_comb begin
    head_nxt  = head_r + {1'b0, do_pop};
    tail_nxt  = tail_r + n_push;
    count_nxt = count_r + {1'b0, n_push} - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[tail_r] <= data_a;
    end
    if (push_b) begin
      mem_r[tail_r + 2'd1] <= data_b;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sql_query_tokenizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sql_query_tokenizer_unit
// Splits a query byte stream into classified tokens.
//
// in_ch takes one query byte per request, end_of_query on the final byte.
// out_ch gives tokens: kind, start offset, length, plus no_token for a bare
// end marker and last_of_query on the final token of each query.
// A byte is handled in the cycle it is accepted; its tokens are registered in a
// four-entry result queue and are given on out_ch from its head, oldest first.
// Throughput is one byte per cycle while the bytes cause no more than one
// token per cycle on average. A byte that closes a word and is itself
// a parenthesis yields two tokens; the queue absorbs them, and in_ch.ready
// drops while fewer than two entries are free, so a receiver stall holds
// the input once three or four tokens are waiting.
// Offsets stop at 4095 and lengths at 4096 within a query.
// After reset, or after the end of a query, the position is zero and no
// word is open; after reset the queue is also empty.
// ----------------------------------------------------------------------------
module sql_query_tokenizer_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  sqt_in_if.sink    in_ch,
  sqt_out_if.source out_ch
);
  import sqt_pkg::*;

  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic             in_word_r, in_word_nxt;
  logic [POS_W-1:0] word_start_r, word_start_nxt;
  logic [LEN_W-1:0] word_len_r, word_len_nxt;
  prefix_t          prefix_r, prefix_nxt;
  logic             all_wc_r, all_wc_nxt;
  logic             first_q_r, first_q_nxt;
  logic [7:0]       last_c_r, last_c_nxt;

  logic             accept;
  logic [7:0]       c;
  logic             eoq;
  logic             is_ws, is_par, is_wc, is_body, start_new;
  logic             word_emit, marker;
  logic [LEN_W-1:0] w_len;
  logic [POS_W-1:0] w_start;
  kind_t            w_kind;
  token_t           word_tok, par_tok, mark_tok, tok_a, tok_b;
  logic             push_a, push_b;
  logic             room;
  token_t           head_tok;

  assign c         = in_ch.char_code;
  assign eoq       = in_ch.end_of_query;
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room;

  always_comb begin
    is_ws     = c inside {8'h20, [8'h09:8'h0d]};
    is_par    = c inside {"(", ")"};
    is_wc     = c inside {["0":"9"], ["A":"Z"], ["a":"z"], "_"};
    is_body   = !is_ws && !is_par;
    start_new = is_body && !in_word_r;

    // word as it stands after this byte
    w_start     = in_word_r ? word_start_r : byte_pos_r;
    prefix_nxt  = prefix_r;
    all_wc_nxt  = all_wc_r;
    first_q_nxt = first_q_r;
    last_c_nxt  = last_c_r;
    w_len       = word_len_r;
    if (is_body) begin
      if (start_new) begin
        w_len       = LEN_W'(1);
        prefix_nxt[0] = c;
        all_wc_nxt  = is_wc;
        first_q_nxt = (c == "'");
      end else begin
        if (word_len_r < LEN_W'(PREFIX_DEPTH)) begin
          prefix_nxt[word_len_r[2:0]] = c;
        end
        if (word_len_r < LEN_MAX) begin
          w_len = word_len_r + LEN_W'(1);
        end
        all_wc_nxt = all_wc_r && is_wc;
      end
      last_c_nxt = c;
    end
    w_kind = classify(prefix_nxt, w_len, all_wc_nxt, first_q_nxt, last_c_nxt);

    word_emit = (in_word_r || is_body) && (!is_body || eoq);
    marker    = eoq && !word_emit && !is_par;

    word_tok = '{kind: w_kind, start: w_start, length: w_len,
                 no_token: 1'b0, last: 1'b0};
    par_tok  = '{kind: KIND_COLUMN, start: byte_pos_r, length: LEN_W'(1),
                 no_token: 1'b0, last: 1'b0};
    mark_tok = '{kind: KIND_SELECT, start: '0, length: '0,
                 no_token: 1'b1, last: 1'b1};

    tok_b      = par_tok;
    tok_b.last = eoq;
    if (word_emit) begin
      tok_a      = word_tok;
      tok_a.last = eoq && !is_par;
    end else if (is_par) begin
      tok_a      = par_tok;
      tok_a.last = eoq;
    end else begin
      tok_a = mark_tok;
    end
    push_a = accept && (word_emit || is_par || marker);
    push_b = accept && word_emit && is_par;

    // state update
    byte_pos_nxt   = byte_pos_r;
    in_word_nxt    = in_word_r;
    word_start_nxt = word_start_r;
    word_len_nxt   = word_len_r;
    if (accept) begin
      if (eoq) begin
        byte_pos_nxt = '0;
      end else if (byte_pos_r < POS_MAX) begin
        byte_pos_nxt = byte_pos_r + POS_W'(1);
      end
      if (word_emit) begin
        in_word_nxt    = 1'b0;
        word_start_nxt = '0;
        word_len_nxt   = '0;
      end else if (is_body) begin
        in_word_nxt    = 1'b1;
        word_start_nxt = w_start;
        word_len_nxt   = w_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      in_word_r    <= 1'b0;
      word_start_r <= '0;
      word_len_r   <= '0;
      all_wc_r     <= 1'b1;
      first_q_r    <= 1'b0;
      last_c_r     <= '0;
    end else begin
      byte_pos_r   <= byte_pos_nxt;
      in_word_r    <= in_word_nxt;
      word_start_r <= word_start_nxt;
      word_len_r   <= word_len_nxt;
      if (accept && word_emit) begin
        all_wc_r  <= 1'b1;
        first_q_r <= 1'b0;
        last_c_r  <= '0;
      end else if (accept) begin
        all_wc_r  <= all_wc_nxt;
        first_q_r <= first_q_nxt;
        last_c_r  <= last_c_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix_r <= prefix_nxt;
    end
  end

  sqt_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (push_a),
    .push_b (push_b),
    .data_a (tok_a),
    .data_b (tok_b),
    .room   (room),
    .valid  (out_ch.valid),
    .pop    (out_ch.ready),
    .data   (head_tok)
  );

  assign out_ch.token_kind    = head_tok.kind;
  assign out_ch.token_start   = head_tok.start;
  assign out_ch.token_length  = head_tok.length;
  assign out_ch.no_token      = head_tok.no_token;
  assign out_ch.last_of_query = head_tok.last;

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.no_token |-> out_ch.last_of_query && out_ch.token_length == '0)
    else $error("end marker not last or has length");

  a_token_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.no_token |-> out_ch.token_length != '0)
    else $error("token with zero length");

  a_query_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && eoq |=> byte_pos_r == '0 && !in_word_r && word_len_r == '0)
    else $error("state not cleared after end of query");

  a_open_word_length: assert property (@(posedge clk) disable iff (!rst_n)
    in_word_r |-> word_len_r != '0)
    else $error("open word with zero length");

  a_two_tokens_need_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_b |-> push_a && room)
    else $error("second token pushed without first or without room");

endmodule
`default_nettype wire

>>> verif/sqt_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_token_checker
// Follows every accepted query byte with its own lexer, queues the tokens it
// should cause and compares each token taken from the token channel, field
// by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module sqt_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  sqt_in_if           in_ch,
  sqt_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending_tokens,
  output int unsigned tokens_checked
);
  import sqt_pkg::*;

  logic [POS_W-1:0] byte_pos;
  logic             word_open;
  logic [POS_W-1:0] word_begin;
  logic [LEN_W-1:0] word_len;
  logic [7:0]       word_head [PREFIX_DEPTH];
  logic             only_word_chars;
  logic             opens_with_quote;
  logic [7:0]       latest_char;
  token_t           tokens_due [$];

  function automatic void clear_word();
    word_open        = 1'b0;
    word_begin       = '0;
    word_len         = '0;
    only_word_chars  = 1'b1;
    opens_with_quote = 1'b0;
    latest_char      = 8'h00;
  endfunction

  function automatic kind_t word_kind();
    kind_t       k;
    logic [55:0] txt;
    txt = {word_head[0], word_head[1], word_head[2], word_head[3],
           word_head[4], word_head[5], word_head[6]};
    if (only_word_chars) begin
      k = KIND_COLUMN;
    end else if (opens_with_quote && latest_char == "'") begin
      k = KIND_LITERAL;
    end else begin
      k = KIND_UNKNOWN;
    end
    case (word_len)
      LEN_W'(1): if (txt[55 -: 8] inside {"=", ">", "<"}) k = KIND_OPERATOR;
      LEN_W'(2): begin
        if (txt[55 -: 16] inside {">=", "<=", "!="}) begin
          k = KIND_OPERATOR;
        end else if (txt[55 -: 16] == "OR") begin
          k = KIND_OR;
        end
      end
      LEN_W'(3): if (txt[55 -: 24] == "AND") k = KIND_AND;
      LEN_W'(4): if (txt[55 -: 32] == "FROM") k = KIND_FROM;
      LEN_W'(5): if (txt[55 -: 40] == "WHERE") k = KIND_WHERE;
      LEN_W'(6): if (txt[55 -: 48] == "SELECT") k = KIND_SELECT;
      LEN_W'(7): if (txt == "BETWEEN") k = KIND_BETWEEN;
      default: ;
    endcase
    return k;
  endfunction

  function automatic void queue_token(kind_t k, logic [POS_W-1:0] s,
                                      logic [LEN_W-1:0] l, logic none);
    token_t t;
    t.kind     = k;
    t.start    = s;
    t.length   = l;
    t.no_token = none;
    t.last     = 1'b0;
    tokens_due = {tokens_due, t};
  endfunction

  function automatic void check_field(string name, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] c;
    logic       blank;
    logic       paren;
    logic       word_char;
    int         n;
    token_t     want;
    if (!rst_n) begin
      byte_pos = '0;
      clear_word();
      foreach (word_head[i]) word_head[i] = 8'h00;
      tokens_due.delete();
      fail_count     = 0;
      tokens_checked = 0;
    end else begin
      // token side first: nothing taken at this edge can stem from this byte
      if (out_ch.valid && out_ch.ready) begin
        if (tokens_due.size() == 0) begin
          $error("token with nothing due: kind %0d start %0d length %0d",
                 out_ch.token_kind, out_ch.token_start, out_ch.token_length);
          fail_count++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", want.kind, out_ch.token_kind);
          check_field("token_start", want.start, out_ch.token_start);
          check_field("token_length", want.length, out_ch.token_length);
          check_field("no_token", want.no_token, out_ch.no_token);
          check_field("last_of_query", want.last, out_ch.last_of_query);
          tokens_checked++;
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        c         = in_ch.char_code;
        blank     = (c == " ") || (c >= 8'd9 && c <= 8'd13);
        paren     = (c == "(") || (c == ")");
        word_char = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                    (c >= "a" && c <= "z") || (c == "_");
        n = 0;
        if (blank || paren) begin
          if (word_open) begin
            queue_token(word_kind(), word_begin, word_len, 1'b0);
            n++;
            clear_word();
          end
          if (paren) begin
            queue_token(KIND_COLUMN, byte_pos, LEN_W'(1), 1'b0);
            n++;
          end
        end else begin
          if (!word_open) begin
            word_open        = 1'b1;
            word_begin       = byte_pos;
            word_len         = '0;
            only_word_chars  = 1'b1;
            opens_with_quote = (c == "'");
          end
          if (word_len < LEN_W'(PREFIX_DEPTH)) word_head[word_len[2:0]] = c;
          if (word_len < LEN_MAX) word_len++;
          if (!word_char) only_word_chars = 1'b0;
          latest_char = c;
        end

        if (in_ch.end_of_query) begin
          if (word_open) begin
            queue_token(word_kind(), word_begin, word_len, 1'b0);
            n++;
          end
          // bare end marker when the final byte closes nothing
          if (n == 0) queue_token(KIND_SELECT, '0, '0, 1'b1);
          tokens_due[tokens_due.size() - 1].last = 1'b1;
          byte_pos = '0;
          clear_word();
        end else if (byte_pos < POS_MAX) begin
          byte_pos++;
        end
      end
    end
    pending_tokens = tokens_due.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives query bytes into the tokenizer: a few hand-picked queries, then
// random queries built from keywords, operators, names, literals and
// parentheses, with noise and corrupted queries mixed in. Both channels
// idle at random and the token side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import sqt_pkg::*;

  localparam int RANDOM_BYTES = 480;
  localparam int HOLD_CYCLES  = 300;
  localparam int N_FIXED      = 22;

  logic        clk;
  logic        rst_n;
  logic        calm;
  logic        hold_off_req;
  int unsigned fail_count;
  int unsigned pending_tokens;
  int unsigned tokens_checked;
  int unsigned queries;
  int unsigned bytes_sent;
  logic [7:0]  query_bytes [$];

  string alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";
  string fixed_words [N_FIXED] = '{
    "SELECT", "FROM", "WHERE", "AND", "OR", "BETWEEN",
    "=", ">", ">=", "<", "<=", "!=",
    "select", "SELEC", "FROMM", "ANDY", "OR_", "BETWEENX", "=>", "==", "!", "<>"
  };

  sqt_in_if  in_ch ();
  sqt_out_if out_ch ();

  sql_query_tokenizer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sqt_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens),
    .tokens_checked (tokens_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    query_bytes = {query_bytes, b};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_blank();
    int r;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 5);
      add_byte((r == 5) ? 8'h20 : 8'(9 + r));
    end
  endfunction

  function automatic void add_column();
    repeat ($urandom_range(1, 12)) begin
      add_byte(alnum[$urandom_range(0, alnum.len() - 1)]);
    end
  endfunction

  function automatic void add_literal();
    logic [7:0] c;
    add_byte("'");
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom_range(33, 126)); while (c == "(" || c == ")");
      add_byte(c);
    end
    add_byte("'");
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= c;
    in_ch.end_of_query <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_query();
    for (int i = 0; i < query_bytes.size(); i++) begin
      send_byte(query_bytes[i], i == query_bytes.size() - 1);
    end
    bytes_sent += query_bytes.size();
    queries++;
    query_bytes.delete();
  endtask

  // token side: random stalls, plus one long hold when asked for
  initial begin : token_sink
    int stall;
    bit held_once;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req && !held_once) begin
        held_once = 1'b1;
        stall     = HOLD_CYCLES;
      end else begin
        stall = idle_len();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int random_bytes;
    int shape;
    int n;
    int pick;
    calm               = 1'b0;
    hold_off_req       = 1'b0;
    queries            = 0;
    bytes_sent         = 0;
    random_bytes       = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.char_code    <= 8'h00;
    in_ch.end_of_query <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-picked queries
    add_text(" ");
    send_query();
    add_text("'");
    send_query();
    add_text("x(");
    send_query();
    add_byte(8'hFF);
    send_query();
    add_byte(8'h00);
    send_query();
    add_text("AND");
    add_byte(8'h09);
    add_text("_9");
    add_byte(8'h0A);
    add_text(")");
    send_query();
    add_text("'a'");
    add_byte(8'h0B);
    add_text(">=");
    add_byte(8'h0C);
    send_query();
    add_text("()");
    send_query();

    while (random_bytes < RANDOM_BYTES) begin
      shape = $urandom_range(0, 9);
      calm  = ($urandom_range(0, 5) == 0);
      if (queries == 10) hold_off_req = 1'b1;
      if (shape == 0) begin
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) add_blank();
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            add_text(fixed_words[$urandom_range(0, N_FIXED - 1)]);
          end else if (pick < 7) begin
            add_column();
          end else if (pick < 8) begin
            add_literal();
          end else begin
            add_text(($urandom_range(0, 1) == 0) ? "(" : ")");
          end
          if ((i < n - 1 || $urandom_range(0, 3) == 0) && $urandom_range(0, 7) != 0) begin
            add_blank();
          end
        end
        // corrupted query: one byte overwritten
        if (shape == 1) begin
          query_bytes[$urandom_range(0, query_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
      random_bytes += query_bytes.size();
      send_query();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d queries, %0d bytes, %0d tokens compared", queries, bytes_sent,
             tokens_checked);
    $display("with random gaps on both channels and one long stall of the token side");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sqt_pkg.sv
hdl/sqt_in_if.sv
hdl/sqt_out_if.sv
hdl/sqt_result_fifo.sv
hdl/sql_query_tokenizer_unit.sv
verif/sqt_token_checker.sv
verif/tb_top.sv
